/* hdl/pps_pkg.sv */
// Shared package for the preemptive priority scheduler.
// Holds payload structs, operation and report codes, sequencer states and limits.
// No dependencies.
`default_nettype none

package pps_pkg;

    localparam int MAX_PROCESSES_DEF = 16;

    localparam logic [19:0] TIME_MAX = 20'hFFFFF;
    localparam logic [23:0] SUM_MAX  = 24'hFFFFFF;

    typedef enum logic [0:0] {
        OP_LOAD = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef enum logic [0:0] {
        KIND_LOAD_ACK = 1'b0,
        KIND_TICK     = 1'b1
    } kind_t;

    typedef struct packed {
        op_t         op;
        logic [15:0] arrival_time;
        logic [15:0] burst_time;
        logic [7:0]  priority_req;
    } req_t;

    typedef struct packed {
        kind_t       kind;
        logic [4:0]  process_number;
        logic        rejected;
        logic [19:0] time_now;
        logic        finished;
        logic [19:0] completion_time;
        logic [19:0] turnaround;
        logic [19:0] waiting;
        logic        all_done;
        logic [23:0] total_turnaround;
        logic [23:0] total_waiting;
    } rsp_t;

    // One process table entry as stored in the slot RAM.
    typedef struct packed {
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [7:0]  prio;
        logic [15:0] remaining;
    } slot_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN,
        S_EXEC,
        S_WAIT,
        S_SUM,
        S_OUT
    } state_t;

endpackage

`default_nettype wire

/* hdl/preemptive_priority_scheduler_top.sv */
// Preemptive priority scheduler: process table in a slot RAM, tick-by-tick selection.
// Depends on pps_pkg and pps_ram.
//
//   channel | signals                 | direction | transfer when
//   req     | req_valid, req_stall, req | in      | req_valid && !req_stall
//   rsp     | rsp_valid, rsp_stall, rsp | out     | rsp_valid && !rsp_stall
//
// A load forms its result in S_LOAD and moves it into the output register in S_OUT.
// A tick scans the loaded processes, then passes through S_EXEC, S_WAIT, S_SUM and S_OUT:
// the scan reads one table slot per cycle through the single RAM read port.
// req_stall is high from transfer until the result enters the output register;
// a result waiting on rsp_stall does not block the next request.
// Reset clears counters, totals, time and done flags; the RAM needs no clearing.
`default_nettype none

module preemptive_priority_scheduler_top
    import pps_pkg::*;
#(
    parameter int MAX_PROCESSES = MAX_PROCESSES_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    localparam int IDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int CNT_W = $clog2(MAX_PROCESSES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PROCESSES);

    state_t state_reg, state_next;

    logic [CNT_W-1:0] loaded_count_reg, loaded_count_next;
    logic [CNT_W-1:0] completed_count_reg, completed_count_next;
    logic [19:0] current_time_reg, current_time_next;
    logic [23:0] tat_sum_reg, tat_sum_next;
    logic [23:0] wt_sum_reg, wt_sum_next;
    logic [MAX_PROCESSES-1:0] done_reg, done_next;

    req_t req_reg, req_next;

    logic [CNT_W-1:0] scan_idx_reg, scan_idx_next;
    logic cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;

    logic have_reg, have_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    slot_t best_reg, best_next;

    logic fin_reg, fin_next;
    logic [19:0] ct_reg, ct_next;
    logic [19:0] tat_reg, tat_next;
    logic [19:0] wt_reg, wt_next;

    rsp_t res_reg, res_next;
    rsp_t rsp_reg, rsp_next;
    logic rsp_valid_reg, rsp_valid_next;

    logic ram_we;
    logic [IDX_W-1:0] ram_waddr;
    slot_t ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [$bits(slot_t)-1:0] ram_rdata;
    slot_t rd_slot;

    logic req_xfer;
    logic issue;
    logic eligible;
    logic better;
    logic out_free;
    logic [15:0] rem_new;
    logic [19:0] time_inc;
    logic [24:0] tat_sum_wide;
    logic [24:0] wt_sum_wide;
    logic [CNT_W+4:0] pnum_wide;

    // Process number of the slot being loaded, truncated to the field width
    function automatic logic [4:0] pnum_wide_load(input logic [CNT_W-1:0] slot);
        logic [CNT_W+4:0] wide;
        wide = (CNT_W + 5)'(slot) + (CNT_W + 5)'(1);
        return wide[4:0];
    endfunction

    pps_ram #(
        .WIDTH ($bits(slot_t)),
        .DEPTH (MAX_PROCESSES)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_slot  = ram_rdata;
    assign req_xfer = req_valid && !req_stall;
    assign issue    = (scan_idx_reg < loaded_count_reg);
    assign out_free = !rsp_valid_reg || !rsp_stall;

    assign eligible = !done_reg[cmp_idx_reg]
                      && ({4'b0, rd_slot.arrival} <= current_time_reg);
    assign better   = !have_reg
                      || (rd_slot.prio < best_reg.prio)
                      || ((rd_slot.prio == best_reg.prio)
                          && (rd_slot.arrival < best_reg.arrival));

    assign rem_new   = (best_reg.remaining == 16'd0) ? 16'd0 : best_reg.remaining - 16'd1;
    assign time_inc  = (current_time_reg == TIME_MAX) ? TIME_MAX : current_time_reg + 20'd1;
    assign tat_sum_wide = {1'b0, tat_sum_reg} + {5'b0, tat_reg};
    assign wt_sum_wide  = {1'b0, wt_sum_reg} + {5'b0, wt_reg};
    assign pnum_wide    = (CNT_W + 5)'(best_idx_reg) + (CNT_W + 5)'(1);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_xfer)
                begin
                    state_next = (req.op == OP_LOAD) ? S_LOAD : S_SCAN;
                end
            end
            S_LOAD:
            begin
                state_next = S_OUT;
            end
            S_SCAN:
            begin
                if (!issue && !cmp_valid_reg)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                state_next = S_SUM;
            end
            S_SUM:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs and RAM control
    always_comb
    begin
        req_stall = (state_reg != S_IDLE);
        ram_raddr = scan_idx_reg[IDX_W-1:0];
        ram_we    = 1'b0;
        ram_waddr = loaded_count_reg[IDX_W-1:0];
        ram_wdata = '{arrival:   req_reg.arrival_time,
                      burst:     req_reg.burst_time,
                      prio:      req_reg.priority_req,
                      remaining: req_reg.burst_time};
        case (state_reg)
            S_LOAD:
            begin
                ram_we = (loaded_count_reg != CNT_MAX);
            end
            S_EXEC:
            begin
                ram_we    = have_reg;
                ram_waddr = best_idx_reg;
                ram_wdata = '{arrival:   best_reg.arrival,
                              burst:     best_reg.burst,
                              prio:      best_reg.prio,
                              remaining: rem_new};
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Datapath
    always_comb
    begin
        loaded_count_next    = loaded_count_reg;
        completed_count_next = completed_count_reg;
        current_time_next    = current_time_reg;
        tat_sum_next         = tat_sum_reg;
        wt_sum_next          = wt_sum_reg;
        done_next            = done_reg;
        req_next             = req_reg;
        scan_idx_next        = scan_idx_reg;
        cmp_valid_next       = cmp_valid_reg;
        cmp_idx_next         = cmp_idx_reg;
        have_next            = have_reg;
        best_idx_next        = best_idx_reg;
        best_next            = best_reg;
        fin_next             = fin_reg;
        ct_next              = ct_reg;
        tat_next             = tat_reg;
        wt_next              = wt_reg;
        res_next             = res_reg;
        rsp_next             = rsp_reg;
        rsp_valid_next       = rsp_valid_reg;

        // Drop the output once taken
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_xfer)
                begin
                    req_next       = req;
                    scan_idx_next  = '0;
                    cmp_valid_next = 1'b0;
                    have_next      = 1'b0;
                end
            end
            S_LOAD:
            begin
                res_next = '0;
                res_next.kind = KIND_LOAD_ACK;
                if (loaded_count_reg == CNT_MAX)
                begin
                    res_next.rejected = 1'b1;
                end
                else
                begin
                    done_next[loaded_count_reg[IDX_W-1:0]] = 1'b0;
                    loaded_count_next = loaded_count_reg + CNT_W'(1);
                    res_next.process_number = pnum_wide_load(loaded_count_reg);
                end
                res_next.time_now         = current_time_reg;
                res_next.all_done         = (completed_count_reg == loaded_count_next);
                res_next.total_turnaround = tat_sum_reg;
                res_next.total_waiting    = wt_sum_reg;
            end
            S_SCAN:
            begin
                cmp_valid_next = issue;
                cmp_idx_next   = scan_idx_reg[IDX_W-1:0];
                if (issue)
                begin
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                end
                if (cmp_valid_reg && eligible && better)
                begin
                    have_next     = 1'b1;
                    best_idx_next = cmp_idx_reg;
                    best_next     = rd_slot;
                end
            end
            S_EXEC:
            begin
                current_time_next = time_inc;
                fin_next = 1'b0;
                ct_next  = '0;
                tat_next = '0;
                if (have_reg && (rem_new == 16'd0))
                begin
                    fin_next = 1'b1;
                    ct_next  = time_inc;
                    tat_next = time_inc - {4'b0, best_reg.arrival};
                    done_next[best_idx_reg] = 1'b1;
                    completed_count_next = completed_count_reg + CNT_W'(1);
                end
            end
            S_WAIT:
            begin
                wt_next = '0;
                if (fin_reg)
                begin
                    if (tat_reg > {4'b0, best_reg.burst})
                    begin
                        wt_next = tat_reg - {4'b0, best_reg.burst};
                    end
                    tat_sum_next = tat_sum_wide[24] ? SUM_MAX : tat_sum_wide[23:0];
                end
            end
            S_SUM:
            begin
                if (fin_reg)
                begin
                    wt_sum_next = wt_sum_wide[24] ? SUM_MAX : wt_sum_wide[23:0];
                end
                res_next.kind             = KIND_TICK;
                res_next.process_number   = have_reg ? pnum_wide[4:0] : 5'd0;
                res_next.rejected         = 1'b0;
                res_next.time_now         = current_time_reg;
                res_next.finished         = fin_reg;
                res_next.completion_time  = ct_reg;
                res_next.turnaround       = tat_reg;
                res_next.waiting          = wt_reg;
                res_next.all_done         = (completed_count_reg == loaded_count_reg);
                res_next.total_turnaround = tat_sum_reg;
                res_next.total_waiting    = wt_sum_next;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            loaded_count_reg    <= '0;
            completed_count_reg <= '0;
            current_time_reg    <= '0;
            tat_sum_reg         <= '0;
            wt_sum_reg          <= '0;
            done_reg            <= '0;
            scan_idx_reg        <= '0;
            cmp_valid_reg       <= 1'b0;
            have_reg            <= 1'b0;
            fin_reg             <= 1'b0;
            rsp_valid_reg       <= 1'b0;
        end
        else
        begin
            state_reg           <= state_next;
            loaded_count_reg    <= loaded_count_next;
            completed_count_reg <= completed_count_next;
            current_time_reg    <= current_time_next;
            tat_sum_reg         <= tat_sum_next;
            wt_sum_reg          <= wt_sum_next;
            done_reg            <= done_next;
            scan_idx_reg        <= scan_idx_next;
            cmp_valid_reg       <= cmp_valid_next;
            have_reg            <= have_next;
            fin_reg             <= fin_next;
            rsp_valid_reg       <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        cmp_idx_reg  <= cmp_idx_next;
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
        ct_reg       <= ct_next;
        tat_reg      <= tat_next;
        wt_reg       <= wt_next;
        res_reg      <= res_next;
        rsp_reg      <= rsp_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        completed_count_reg <= loaded_count_reg)
        else $error("completed count exceeds loaded count");

    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(done_reg) == int'(completed_count_reg))
        else $error("done flags disagree with completed count");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmp_valid_reg |-> ((CNT_W + 1)'(cmp_idx_reg) < (CNT_W + 1)'(loaded_count_reg)))
        else $error("scan compared an unloaded slot");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) |=> (current_time_reg == TIME_MAX
                                   || current_time_reg == $past(current_time_reg) + 20'd1))
        else $error("time did not advance on tick");

endmodule

`default_nettype wire

/* hdl/pps_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                     clk,
    input  wire logic                                     we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* dv/testbench.sv */
// Self-checking testbench for preemptive_priority_scheduler_top.
// Directed table then random loads and ticks, checked against a tick-accurate scheduler model.
// Depends on pps_pkg and the scheduler RTL.

module testbench;
    import pps_pkg::*;

    localparam int SLOTS        = 16;
    localparam int GAP_MAX      = 14;
    localparam int RANDOM_ITEMS = 950;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        req_t item;
        bit   typed;
        rsp_t want;
    } dir_row_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    // scheduler model state
    logic [15:0] slot_arrival [SLOTS];
    logic [15:0] slot_burst [SLOTS];
    logic [15:0] slot_left [SLOTS];
    logic [7:0]  slot_prio [SLOTS];
    bit          slot_done [SLOTS];
    int unsigned n_loaded    = 0;
    int unsigned n_completed = 0;
    logic [19:0] now_time    = '0;
    logic [23:0] tat_sum     = '0;
    logic [23:0] wait_sum    = '0;

    rsp_t        pending_reports[$];
    dir_row_t    dir_rows[$];
    rsp_t        head_report;
    int unsigned stall_left    = 0;
    int unsigned fail_count    = 0;
    int unsigned items_sent    = 0;
    int unsigned loads_refused = 0;
    int unsigned idle_ticks    = 0;
    bit          calm          = 1'b0;

    preemptive_priority_scheduler_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [23:0] sum_sat(logic [23:0] acc, logic [19:0] inc);
        longint s;
        s = longint'(acc) + longint'(inc);
        return (s > longint'(SUM_MAX)) ? SUM_MAX : 24'(s);
    endfunction

    // Advance the model by one request and return the report it produces.
    function automatic rsp_t schedule(req_t r);
        rsp_t        o;
        int          best;
        bit          found;
        logic [19:0] tat;
        logic [19:0] wt;
        o = '0;
        if (r.op == OP_LOAD)
        begin
            o.kind = KIND_LOAD_ACK;
            if (n_loaded >= SLOTS)
            begin
                o.rejected = 1'b1;
            end
            else
            begin
                slot_arrival[n_loaded] = r.arrival_time;
                slot_burst[n_loaded]   = r.burst_time;
                slot_left[n_loaded]    = r.burst_time;
                slot_prio[n_loaded]    = r.priority_req;
                slot_done[n_loaded]    = 1'b0;
                n_loaded++;
                o.process_number = 5'(n_loaded);
            end
        end
        else
        begin
            o.kind = KIND_TICK;
            found  = 1'b0;
            best   = 0;
            for (int i = 0; i < n_loaded; i++)
            begin
                if (!slot_done[i] && 20'(slot_arrival[i]) <= now_time)
                begin
                    if (!found || slot_prio[i] < slot_prio[best]
                        || (slot_prio[i] == slot_prio[best]
                            && slot_arrival[i] < slot_arrival[best]))
                    begin
                        best  = i;
                        found = 1'b1;
                    end
                end
            end
            if (now_time != TIME_MAX)
                now_time = now_time + 20'd1;
            if (found)
            begin
                o.process_number = 5'(best + 1);
                if (slot_left[best] != 16'd0)
                    slot_left[best] = slot_left[best] - 16'd1;
                if (slot_left[best] == 16'd0)
                begin
                    tat = now_time - 20'(slot_arrival[best]);
                    wt  = (tat > 20'(slot_burst[best])) ? tat - 20'(slot_burst[best]) : '0;
                    o.finished        = 1'b1;
                    o.completion_time = now_time;
                    o.turnaround      = tat;
                    o.waiting         = wt;
                    slot_done[best]   = 1'b1;
                    n_completed++;
                    tat_sum  = sum_sat(tat_sum, tat);
                    wait_sum = sum_sat(wait_sum, wt);
                end
            end
            else
            begin
                idle_ticks++;
            end
        end
        o.time_now         = now_time;
        o.all_done         = (n_completed == n_loaded);
        o.total_turnaround = tat_sum;
        o.total_waiting    = wait_sum;
        return o;
    endfunction

    function automatic req_t mk_load(int arrival, int burst, int prio);
        req_t r;
        r.op           = OP_LOAD;
        r.arrival_time = 16'(arrival);
        r.burst_time   = 16'(burst);
        r.priority_req = 8'(prio);
        return r;
    endfunction

    // Tick payload fields are ignored; fill them with noise.
    function automatic req_t mk_tick();
        req_t r;
        r.op           = OP_TICK;
        r.arrival_time = 16'($urandom);
        r.burst_time   = 16'($urandom);
        r.priority_req = 8'($urandom);
        return r;
    endfunction

    function automatic rsp_t report(kind_t k, int pnum, int tnow, bit fin, int ct, int tat,
                                    int wt, bit done, int ttat, int twt);
        rsp_t o;
        o.kind             = k;
        o.process_number   = 5'(pnum);
        o.rejected         = 1'b0;
        o.time_now         = 20'(tnow);
        o.finished         = fin;
        o.completion_time  = 20'(ct);
        o.turnaround       = 20'(tat);
        o.waiting          = 20'(wt);
        o.all_done         = done;
        o.total_turnaround = 24'(ttat);
        o.total_waiting    = 24'(twt);
        return o;
    endfunction

    task automatic add_row(req_t item, bit typed, rsp_t want);
        dir_row_t row;
        row.item  = item;
        row.typed = typed;
        row.want  = want;
        dir_rows.push_back(row);
    endtask

    // Mostly ticks; loads are spaced out so processes keep arriving through the run.
    function automatic req_t pick_random();
        int roll;
        int now;
        int arrival;
        roll = $urandom_range(0, 99);
        now  = int'(now_time);
        if (roll >= 3)
            return mk_tick();
        if (n_loaded >= SLOTS)
            return mk_load($urandom, $urandom, $urandom);
        if ($urandom_range(0, 2) == 0)
            arrival = (now > 10) ? now - $urandom_range(0, 10) : $urandom_range(0, now);
        else
            arrival = now + $urandom_range(0, 40);
        return mk_load(arrival, $urandom_range(0, 40),
                       $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 255));
    endfunction

    // Present one request, hold it until the transfer, then record its report.
    task automatic transfer(req_t item, bit typed, rsp_t want);
        int unsigned gap;
        rsp_t        model_rsp;
        gap = calm ? 0 : $urandom_range(0, GAP_MAX);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        model_rsp = schedule(item);
        pending_reports.push_back(typed ? want : model_rsp);
        items_sent++;
        if (items_sent % 64 == 0)
            calm = ($urandom_range(0, 3) == 0);
    endtask

    task automatic check_field(string name, logic [23:0] want, logic [23:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    task automatic compare_report(rsp_t want, rsp_t got);
        check_field("kind", want.kind, got.kind);
        check_field("process_number", want.process_number, got.process_number);
        check_field("rejected", want.rejected, got.rejected);
        check_field("time_now", want.time_now, got.time_now);
        check_field("finished", want.finished, got.finished);
        check_field("completion_time", want.completion_time, got.completion_time);
        check_field("turnaround", want.turnaround, got.turnaround);
        check_field("waiting", want.waiting, got.waiting);
        check_field("all_done", want.all_done, got.all_done);
        check_field("total_turnaround", want.total_turnaround, got.total_turnaround);
        check_field("total_waiting", want.total_waiting, got.total_waiting);
    endtask

    // Report side: check each transfer, then draw the stall for the next one.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_reports.size() == 0)
                begin
                    $error("report with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    head_report = pending_reports.pop_front();
                    compare_report(head_report, rsp);
                end
                stall_left = calm ? 0 : $urandom_range(0, GAP_MAX);
            end
            else if (stall_left != 0)
            begin
                stall_left--;
            end
            rsp_stall <= (stall_left != 0);
        end
    end

    initial
    begin
        // idle tick, zero burst, extremes, priority and arrival ties, preemption
        add_row(mk_tick(), 1'b1, report(KIND_TICK, 0, 1, 0, 0, 0, 0, 1, 0, 0));
        add_row(mk_load(0, 0, 0), 1'b1, report(KIND_LOAD_ACK, 1, 1, 0, 0, 0, 0, 0, 0, 0));
        add_row(mk_tick(), 1'b1, report(KIND_TICK, 1, 2, 1, 2, 2, 2, 1, 2, 2));
        add_row(mk_load(65535, 65535, 255), 1'b1,
                report(KIND_LOAD_ACK, 2, 2, 0, 0, 0, 0, 0, 2, 2));
        add_row(mk_load(2, 3, 7), 1'b0, '0);
        add_row(mk_load(3, 2, 7), 1'b0, '0);
        add_row(mk_load(2, 2, 7), 1'b0, '0);
        add_row(mk_load(6, 1, 1), 1'b0, '0);
        repeat (11) add_row(mk_tick(), 1'b0, '0);
        add_row(mk_load(0, 1, 128), 1'b0, '0);
        add_row(mk_tick(), 1'b0, '0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            transfer(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

        begin
            int unsigned counted;
            req_t        item;
            counted = 0;
            while (counted < RANDOM_ITEMS)
            begin
                item = pick_random();
                if (item.op == OP_LOAD && n_loaded >= SLOTS)
                    loads_refused++;
                else
                    counted++;
                transfer(item, 1'b0, '0);
            end
        end
        req_valid <= 1'b0;

        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d requests: %0d processes loaded, %0d loads refused on a full table",
                 items_sent, n_loaded, loads_refused);
        $display("%0d processes completed, %0d idle ticks, final time %0d",
                 n_completed, idle_ticks, now_time);
        if (fail_count == 0)
            $display("preemptive_priority_scheduler_top regression: pass");
        else
            $display("preemptive_priority_scheduler_top regression: fail");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("preemptive_priority_scheduler_top regression: fail");
        $finish;
    end

endmodule
